// ===== hdl/v3alu_pkg.sv =====
// Shared widths, word type and command codes of the three-component vector ALU.
`timescale 1ns / 1ps

package v3alu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Full product of two words and the sum of three such products.
    localparam int PROD_W = 2 * WORD_BITS;
    localparam int ACC_W  = 2 * WORD_BITS + 2;
    // Square root: radicand remainder, root, and the rounded magnitude.
    localparam int SQ_W   = 2 * WORD_BITS + 1;
    localparam int RT_W   = WORD_BITS;
    localparam int MAG_W  = WORD_BITS + 1;
    // Dividend of the unit vector division.
    localparam int NUM_W  = WORD_BITS + FRAC_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_NEG   = 3'd2,
        CMD_SCALE = 3'd3,
        CMD_DOT   = 3'd4,
        CMD_CROSS = 3'd5,
        CMD_MAG   = 3'd6,
        CMD_UNIT  = 3'd7
    } cmd_t;

endpackage

// ===== hdl/v3alu_req_if.sv =====
// Request channel of the vector ALU: command, two vectors and a scalar.
`timescale 1ns / 1ps

interface v3alu_req_if import v3alu_pkg::*;;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    word_t       a_x;
    word_t       a_y;
    word_t       a_z;
    word_t       b_x;
    word_t       b_y;
    word_t       b_z;
    word_t       scalar_in;

    modport source (
        output valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
        input  ready
    );
    modport sink (
        input  valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
        output ready
    );
endinterface

// ===== hdl/v3alu_rsp_if.sv =====
// Result channel of the vector ALU: result vector, scalar and flags.
`timescale 1ns / 1ps

interface v3alu_rsp_if import v3alu_pkg::*;;
    logic   valid;
    logic   ready;
    word_t  r_x;
    word_t  r_y;
    word_t  r_z;
    word_t  scalar_out;
    logic   overflow;
    logic   div_zero;

    modport source (
        output valid, r_x, r_y, r_z, scalar_out, overflow, div_zero,
        input  ready
    );
    modport sink (
        input  valid, r_x, r_y, r_z, scalar_out, overflow, div_zero,
        output ready
    );
endinterface

// ===== hdl/vec3_fixed_point_alu_unit.sv =====
// Pipelined three-component vector ALU in signed Q16.16 fixed point.
`timescale 1ns / 1ps

// This unit takes one transfer per clock on the request channel and returns exactly one
// transfer on the result channel for each, in order. Every command travels the same
// pipeline of 86 stages followed by the output register, and the sustained rate is one
// item per cycle. The front end registers the operands, runs six 32x32 multipliers,
// sums the products, saturates add, subtract and negate results, and rounds and
// saturates scale, dot and cross results. Magnitude and unit requests then continue
// through a square root pipeline that settles one root bit per stage (32 stages), a
// rounding stage, a dividend setup stage, and three parallel restoring dividers that
// settle one quotient bit per stage (48 stages). Products round to nearest with ties
// toward plus infinity; the magnitude rounds to nearest; unit components round to
// nearest with ties away from zero. Any saturated result raises overflow, and a unit
// request on the zero vector returns zeros with div_zero set. Throughput drops only
// when the result channel holds off ready while the output register is full and the
// last stage is occupied; then the whole pipeline holds, while an empty last stage
// still lets the pipeline move.
module vec3_fixed_point_alu_unit import v3alu_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    v3alu_req_if.sink     req,
    v3alu_rsp_if.source   rsp
);

    // Stage indexes: four front-end stages, the square root stages, the rounding stage,
    // the dividend setup stage and the divider stages.
    localparam int STG_ACC  = 2;
    localparam int STG_RND  = 3;
    localparam int STG_R    = 4 + RT_W;
    localparam int STG_P    = STG_R + 1;
    localparam int STG_LAST = STG_P + NUM_W;
    localparam int NSTG     = STG_LAST + 1;

    typedef struct packed {
        cmd_t   cmd;
        word_t  v0;
        word_t  v1;
        word_t  v2;
        word_t  sc;
        logic   ovf;
        logic   dz;
    } carry_t;

    typedef struct packed {
        logic   ovf;
        word_t  val;
    } sat_t;

    // Round a double-width value to nearest (ties up), drop the fraction and saturate.
    function automatic sat_t rnd_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]           r;
        logic signed [ACC_W-FRAC_BITS-1:0] sh;
        logic                              fits;
        sat_t                              o;
        r    = v + (ACC_W'(1) << (FRAC_BITS - 1));
        sh   = r[ACC_W-1:FRAC_BITS];
        fits = (sh[ACC_W-FRAC_BITS-1:WORD_BITS-1] == '0)
            || (sh[ACC_W-FRAC_BITS-1:WORD_BITS-1] == '1);
        o.ovf = !fits;
        o.val = fits ? sh[WORD_BITS-1:0] : (sh[ACC_W-FRAC_BITS-1] ? WORD_MIN : WORD_MAX);
        return o;
    endfunction

    // Saturate a sum that grew by one bit.
    function automatic sat_t sat1(input logic signed [WORD_BITS:0] v);
        sat_t o;
        o.ovf = v[WORD_BITS] != v[WORD_BITS-1];
        o.val = o.ovf ? (v[WORD_BITS] ? WORD_MIN : WORD_MAX) : v[WORD_BITS-1:0];
        return o;
    endfunction

    logic   vld_reg [NSTG];
    carry_t cr_reg  [NSTG];
    carry_t cr_next [NSTG];
    carry_t cr0_next;

    logic   adv;
    logic   take_out;

    // Front-end datapath registers.
    word_t                     ma_reg  [6];
    word_t                     mb_reg  [6];
    word_t                     ma_next [6];
    word_t                     mb_next [6];
    logic signed [PROD_W-1:0]  p_reg   [6];
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic signed [ACC_W-1:0]   acc_next [3];

    // Square root pipeline: index 0 is loaded by the rounding stage.
    logic [SQ_W-1:0]  sq_rem_reg   [RT_W+1];
    logic [RT_W-1:0]  sq_root_reg  [RT_W+1];
    logic [SQ_W-1:0]  sq_rem_next  [RT_W];
    logic [RT_W-1:0]  sq_root_next [RT_W];

    logic [MAG_W-1:0] m_reg;
    logic [MAG_W-1:0] m_next;

    // Dividers: index 0 is loaded by the dividend setup stage.
    logic [MAG_W-1:0] dm_reg    [NUM_W+1];
    logic [MAG_W-1:0] drem_reg  [3][NUM_W+1];
    logic [NUM_W-1:0] dnq_reg   [3][NUM_W+1];
    logic [MAG_W-1:0] drem_next [3][NUM_W];
    logic [NUM_W-1:0] dnq_next  [3][NUM_W];
    logic [NUM_W-1:0] dnum_next [3];

    // Output register.
    logic   out_valid_reg;
    word_t  out_r_reg [3];
    word_t  out_sc_reg;
    logic   out_ovf_reg;
    logic   out_dz_reg;
    word_t  fin_r [3];
    logic   fin_ovf;

    // The pipeline moves whenever its last stage is empty or the output register can
    // take that stage's item.
    assign take_out  = rsp.ready || !out_valid_reg;
    assign adv       = !vld_reg[STG_LAST] || take_out;
    assign req.ready = adv;

    // Command decode, multiplier operand selection and the one-word add, subtract and
    // negate, all ahead of the first register.
    always_comb
    begin
        cmd_t  c;
        word_t a [3];
        word_t b [3];
        sat_t  s [3];
        c    = cmd_t'(req.command);
        a[0] = req.a_x;
        a[1] = req.a_y;
        a[2] = req.a_z;
        b[0] = req.b_x;
        b[1] = req.b_y;
        b[2] = req.b_z;
        for (int i = 0; i < 6; i++)
        begin
            ma_next[i] = a[i % 3];
            mb_next[i] = a[i % 3];
        end
        case (c)
            CMD_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mb_next[i] = req.scalar_in;
                end
            end
            CMD_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mb_next[i] = b[i];
                end
            end
            CMD_CROSS:
            begin
                ma_next[0] = a[1]; mb_next[0] = b[2];
                ma_next[1] = a[2]; mb_next[1] = b[1];
                ma_next[2] = a[2]; mb_next[2] = b[0];
                ma_next[3] = a[0]; mb_next[3] = b[2];
                ma_next[4] = a[0]; mb_next[4] = b[1];
                ma_next[5] = a[1]; mb_next[5] = b[0];
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < 3; i++)
        begin
            case (c)
                CMD_ADD: s[i] = sat1((WORD_BITS+1)'(a[i]) + (WORD_BITS+1)'(b[i]));
                CMD_SUB: s[i] = sat1((WORD_BITS+1)'(a[i]) - (WORD_BITS+1)'(b[i]));
                default: s[i] = sat1((WORD_BITS+1)'(0) - (WORD_BITS+1)'(a[i]));
            endcase
        end

        cr0_next.cmd = c;
        cr0_next.sc  = '0;
        cr0_next.dz  = 1'b0;
        if (c == CMD_ADD || c == CMD_SUB || c == CMD_NEG)
        begin
            cr0_next.v0  = s[0].val;
            cr0_next.v1  = s[1].val;
            cr0_next.v2  = s[2].val;
            cr0_next.ovf = s[0].ovf | s[1].ovf | s[2].ovf;
        end
        else
        begin
            // Scale, dot, cross, magnitude and unit carry the first vector; unit keeps it for the divider stages.
            cr0_next.v0  = a[0];
            cr0_next.v1  = a[1];
            cr0_next.v2  = a[2];
            cr0_next.ovf = 1'b0;
        end
    end

    // Product sums: each accumulator lane picks the combination its command needs.
    always_comb
    begin
        logic signed [ACC_W-1:0] pe [6];
        for (int i = 0; i < 6; i++)
        begin
            pe[i] = ACC_W'(p_reg[i]);
        end
        case (cr_reg[1].cmd)
            CMD_SCALE:
            begin
                acc_next[0] = pe[0];
                acc_next[1] = pe[1];
                acc_next[2] = pe[2];
            end
            CMD_CROSS:
            begin
                acc_next[0] = pe[0] - pe[1];
                acc_next[1] = pe[2] - pe[3];
                acc_next[2] = pe[4] - pe[5];
            end
            default:
            begin
                acc_next[0] = pe[0] + pe[1] + pe[2];
                acc_next[1] = pe[1];
                acc_next[2] = pe[2];
            end
        endcase
    end

    // Square root: stage j settles root bit RT_W-1-j by trying (r + 2^k)^2 against the
    // remainder of the radicand.
    for (genvar j = 0; j < RT_W; j++)
    begin : g_sqrt
        localparam int K = RT_W - 1 - j;
        logic [SQ_W-1:0] trial;
        logic            ge;
        assign trial = (SQ_W'(sq_root_reg[j]) << (K + 1)) + (SQ_W'(1) << (2 * K));
        assign ge    = sq_rem_reg[j] >= trial;
        assign sq_rem_next[j]  = ge ? sq_rem_reg[j] - trial : sq_rem_reg[j];
        assign sq_root_next[j] = ge ? (sq_root_reg[j] | (RT_W'(1) << K)) : sq_root_reg[j];
    end

    // Round the root to nearest: round up when the remainder exceeds the root.
    assign m_next = MAG_W'(sq_root_reg[RT_W])
                  + MAG_W'(sq_rem_reg[RT_W] > SQ_W'(sq_root_reg[RT_W]));

    // Dividend of each unit component: |a| scaled up, plus half the divisor.
    always_comb
    begin
        word_t           v [3];
        logic [WORD_BITS-1:0] u;
        v[0] = cr_reg[STG_R].v0;
        v[1] = cr_reg[STG_R].v1;
        v[2] = cr_reg[STG_R].v2;
        for (int l = 0; l < 3; l++)
        begin
            u = v[l][WORD_BITS-1] ? WORD_BITS'(-v[l]) : v[l];
            dnum_next[l] = (NUM_W'(u) << FRAC_BITS) + NUM_W'(m_reg >> 1);
        end
    end

    // Restoring dividers, one quotient bit per stage; the dividend shifts out at the
    // top while quotient bits shift in at the bottom.
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        for (genvar j = 0; j < NUM_W; j++)
        begin : g_div
            logic [MAG_W:0] t;
            logic           ge;
            assign t  = {drem_reg[l][j], dnq_reg[l][j][NUM_W-1]};
            assign ge = t >= {1'b0, dm_reg[j]};
            assign drem_next[l][j] = ge ? MAG_W'(t - {1'b0, dm_reg[j]}) : t[MAG_W-1:0];
            assign dnq_next[l][j]  = {dnq_reg[l][j][NUM_W-2:0], ge};
        end
    end

    // Control fields and results carried along the pipeline.
    always_comb
    begin
        sat_t rs [3];
        logic [MAG_W-1:0] m;
        cr_next[0] = cr0_next;
        for (int i = 1; i < NSTG; i++)
        begin
            cr_next[i] = cr_reg[i-1];
        end

        // Rounding stage for scale, dot and cross.
        for (int i = 0; i < 3; i++)
        begin
            rs[i] = rnd_sat(acc_reg[i]);
        end
        case (cr_reg[STG_ACC].cmd) inside
            CMD_SCALE, CMD_CROSS:
            begin
                cr_next[STG_RND].v0  = rs[0].val;
                cr_next[STG_RND].v1  = rs[1].val;
                cr_next[STG_RND].v2  = rs[2].val;
                cr_next[STG_RND].ovf = rs[0].ovf | rs[1].ovf | rs[2].ovf;
            end
            CMD_DOT:
            begin
                cr_next[STG_RND].v0  = '0;
                cr_next[STG_RND].v1  = '0;
                cr_next[STG_RND].v2  = '0;
                cr_next[STG_RND].sc  = rs[0].val;
                cr_next[STG_RND].ovf = rs[0].ovf;
            end
            default:
            begin
            end
        endcase

        // Magnitude result and the zero-vector check for unit.
        m = m_next;
        case (cr_reg[STG_R-1].cmd)
            CMD_MAG:
            begin
                cr_next[STG_R].v0 = '0;
                cr_next[STG_R].v1 = '0;
                cr_next[STG_R].v2 = '0;
                if (m > MAG_W'(WORD_MAX))
                begin
                    cr_next[STG_R].sc  = WORD_MAX;
                    cr_next[STG_R].ovf = 1'b1;
                end
                else
                begin
                    cr_next[STG_R].sc = m[WORD_BITS-1:0];
                end
            end
            CMD_UNIT:
            begin
                cr_next[STG_R].dz = (m == '0);
            end
            default:
            begin
            end
        endcase
    end

    // Unit components: apply the sign to each quotient and saturate.
    always_comb
    begin
        carry_t           cl;
        logic [NUM_W-1:0] q;
        word_t            v [3];
        logic             o [3];
        cl   = cr_reg[STG_LAST];
        v[0] = cl.v0;
        v[1] = cl.v1;
        v[2] = cl.v2;
        for (int l = 0; l < 3; l++)
        begin
            q    = dnq_reg[l][NUM_W];
            o[l] = 1'b0;
            if (cl.cmd != CMD_UNIT)
            begin
                fin_r[l] = v[l];
            end
            else if (cl.dz)
            begin
                fin_r[l] = '0;
            end
            else if (!v[l][WORD_BITS-1])
            begin
                o[l]     = q > NUM_W'(WORD_MAX);
                fin_r[l] = o[l] ? WORD_MAX : q[WORD_BITS-1:0];
            end
            else
            begin
                o[l]     = q > (NUM_W'(1) << (WORD_BITS - 1));
                fin_r[l] = o[l] ? WORD_MIN : -q[WORD_BITS-1:0];
            end
        end
        fin_ovf = cl.ovf | o[0] | o[1] | o[2];
    end

    // Valid bits and the output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg[0] <= req.valid;
                for (int i = 1; i < NSTG; i++)
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (take_out)
            begin
                out_valid_reg <= vld_reg[STG_LAST];
            end
        end
    end

    // Datapath registers advance with the valid bits.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                cr_reg[i] <= cr_next[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                ma_reg[i] <= ma_next[i];
                mb_reg[i] <= mb_next[i];
                p_reg[i]  <= PROD_W'(ma_reg[i]) * PROD_W'(mb_reg[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
            sq_rem_reg[0]  <= acc_reg[0][SQ_W-1:0];
            sq_root_reg[0] <= '0;
            for (int j = 0; j < RT_W; j++)
            begin
                sq_rem_reg[j+1]  <= sq_rem_next[j];
                sq_root_reg[j+1] <= sq_root_next[j];
            end
            m_reg     <= m_next;
            dm_reg[0] <= m_reg;
            for (int j = 0; j < NUM_W; j++)
            begin
                dm_reg[j+1] <= dm_reg[j];
            end
            for (int l = 0; l < 3; l++)
            begin
                drem_reg[l][0] <= '0;
                dnq_reg[l][0]  <= dnum_next[l];
                for (int j = 0; j < NUM_W; j++)
                begin
                    drem_reg[l][j+1] <= drem_next[l][j];
                    dnq_reg[l][j+1]  <= dnq_next[l][j];
                end
            end
        end
        if (take_out)
        begin
            for (int l = 0; l < 3; l++)
            begin
                out_r_reg[l] <= fin_r[l];
            end
            out_sc_reg  <= (cr_reg[STG_LAST].cmd == CMD_UNIT) ? '0 : cr_reg[STG_LAST].sc;
            out_ovf_reg <= fin_ovf;
            out_dz_reg  <= cr_reg[STG_LAST].dz;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.r_x        = out_r_reg[0];
    assign rsp.r_y        = out_r_reg[1];
    assign rsp.r_z        = out_r_reg[2];
    assign rsp.scalar_out = out_sc_reg;
    assign rsp.overflow   = out_ovf_reg;
    assign rsp.div_zero   = out_dz_reg;

`ifndef SYNTHESIS
    // A zero-vector unit result is all zeros and never reports overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.div_zero |-> rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0
            && rsp.scalar_out == '0 && !rsp.overflow)
        else $error("div_zero result carries nonzero data or overflow");

    // The request side only stalls behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid && !rsp.ready)
        else $error("request stalled without output backpressure");

    // The floor root leaves a remainder of at most twice the root.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STG_R-1] && (cr_reg[STG_R-1].cmd == CMD_MAG
            || cr_reg[STG_R-1].cmd == CMD_UNIT)
        |-> sq_rem_reg[RT_W] <= (SQ_W'(sq_root_reg[RT_W]) << 1))
        else $error("square root remainder out of range");

    // The remainders of the first and third divider lanes stay below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STG_LAST] && cr_reg[STG_LAST].cmd == CMD_UNIT && !cr_reg[STG_LAST].dz
        |-> drem_reg[0][NUM_W] < dm_reg[NUM_W] && drem_reg[2][NUM_W] < dm_reg[NUM_W])
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== test/v3alu_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the RTL; this file holds the shared result record.
`timescale 1ns / 1ps

package v3alu_tb_pkg;
    import v3alu_pkg::*;

    typedef struct packed {
        word_t r_x;
        word_t r_y;
        word_t r_z;
        word_t scalar_out;
        logic  overflow;
        logic  div_zero;
    } v3alu_result_t;
endpackage

// ===== test/v3alu_checker.sv =====
// Checker that predicts every vector ALU result and compares it with the result channel.
`timescale 1ns / 1ps

module v3alu_checker import v3alu_pkg::*; import v3alu_tb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    v3alu_req_if.sink   req_mon,
    v3alu_rsp_if.sink   rsp_mon,
    output int          fail_count,
    output int          pending
);

    v3alu_result_t expected_results[$];

    // Saturate a wide signed value to the word range.
    function automatic word_t clamp_word(input logic signed [129:0] v, inout logic ovf);
        if (v > $signed({98'd0, WORD_MAX}))
        begin
            ovf = 1'b1;
            return WORD_MAX;
        end
        if (v < $signed({{98{1'b1}}, WORD_MIN}))
        begin
            ovf = 1'b1;
            return WORD_MIN;
        end
        return v[WORD_BITS-1:0];
    endfunction

    // Round a sum of products to nearest, ties up, then saturate.
    function automatic word_t round_product(input logic signed [129:0] v, inout logic ovf);
        logic signed [129:0] t;
        t = (v + (130'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return clamp_word(t, ovf);
    endfunction

    function automatic logic signed [129:0] wide(input word_t w);
        return 130'(signed'(w));
    endfunction

    // Rounded integer square root of a nonnegative value below 2^66.
    function automatic logic [129:0] root_rounded(input logic [129:0] n);
        logic [129:0] r;
        logic [129:0] lo;
        logic [129:0] hi;
        logic [129:0] mid;
        lo = 0;
        hi = 130'd1 << 33;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        r = lo;
        if (n - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic v3alu_result_t predict_result(input cmd_t cmd,
        input word_t ax, input word_t ay, input word_t az,
        input word_t bx, input word_t by, input word_t bz, input word_t s);
        v3alu_result_t res;
        logic ovf;
        logic signed [129:0] a[3];
        logic signed [129:0] b[3];
        logic signed [129:0] rv[3];
        logic [129:0] mag;
        logic [129:0] num;
        logic [129:0] q;
        logic signed [129:0] sq;
        res = '0;
        ovf = 1'b0;
        a[0] = wide(ax); a[1] = wide(ay); a[2] = wide(az);
        b[0] = wide(bx); b[1] = wide(by); b[2] = wide(bz);
        case (cmd) inside
            CMD_ADD, CMD_SUB, CMD_NEG:
            begin
                for (int i = 0; i < 3; i++)
                    rv[i] = (cmd == CMD_ADD) ? a[i] + b[i] :
                            (cmd == CMD_SUB) ? a[i] - b[i] : -a[i];
                res.r_x = clamp_word(rv[0], ovf);
                res.r_y = clamp_word(rv[1], ovf);
                res.r_z = clamp_word(rv[2], ovf);
            end
            CMD_SCALE:
            begin
                res.r_x = round_product(a[0] * wide(s), ovf);
                res.r_y = round_product(a[1] * wide(s), ovf);
                res.r_z = round_product(a[2] * wide(s), ovf);
            end
            CMD_DOT:
                res.scalar_out = round_product(a[0]*b[0] + a[1]*b[1] + a[2]*b[2], ovf);
            CMD_CROSS:
            begin
                res.r_x = round_product(a[1]*b[2] - a[2]*b[1], ovf);
                res.r_y = round_product(a[2]*b[0] - a[0]*b[2], ovf);
                res.r_z = round_product(a[0]*b[1] - a[1]*b[0], ovf);
            end
            default:
            begin
                sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
                mag = root_rounded(sq);
                if (cmd == CMD_MAG)
                    res.scalar_out = clamp_word(mag, ovf);
                else if (mag == 0)
                    res.div_zero = 1'b1;
                else
                begin
                    // Divide magnitudes, rounding half away from zero, then restore sign.
                    for (int i = 0; i < 3; i++)
                    begin
                        num = ((a[i] < 0) ? -a[i] : a[i]);
                        q = ((num << FRAC_BITS) + (mag >> 1)) / mag;
                        rv[i] = (a[i] < 0) ? -$signed(q) : $signed(q);
                    end
                    res.r_x = clamp_word(rv[0], ovf);
                    res.r_y = clamp_word(rv[1], ovf);
                    res.r_z = clamp_word(rv[2], ovf);
                end
            end
        endcase
        res.overflow = ovf;
        return res;
    endfunction

    // Append one expected result at the tail of the queue.
    task automatic store_expected(input v3alu_result_t r);
        expected_results = {expected_results, r};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
        input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        v3alu_result_t want;
        if (rst_n && req_mon.valid && req_mon.ready)
            store_expected(predict_result(cmd_t'(req_mon.command),
                req_mon.a_x, req_mon.a_y, req_mon.a_z,
                req_mon.b_x, req_mon.b_y, req_mon.b_z, req_mon.scalar_in));
        if (rst_n && rsp_mon.valid && rsp_mon.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected transfer", 0, 0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp_mon.r_x !== want.r_x) report_mismatch("r_x", rsp_mon.r_x, want.r_x);
                if (rsp_mon.r_y !== want.r_y) report_mismatch("r_y", rsp_mon.r_y, want.r_y);
                if (rsp_mon.r_z !== want.r_z) report_mismatch("r_z", rsp_mon.r_z, want.r_z);
                if (rsp_mon.scalar_out !== want.scalar_out)
                    report_mismatch("scalar_out", rsp_mon.scalar_out, want.scalar_out);
                if (rsp_mon.overflow !== want.overflow)
                    report_mismatch("overflow", rsp_mon.overflow, want.overflow);
                if (rsp_mon.div_zero !== want.div_zero)
                    report_mismatch("div_zero", rsp_mon.div_zero, want.div_zero);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the vector ALU testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top import v3alu_pkg::*;;

    // The block is a fixed 87-stage pipeline; the drain wait covers it with margin.
    localparam int PIPE_CYCLES = 87;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit calm_stretch = 1'b0;

    v3alu_req_if req ();
    v3alu_rsp_if rsp ();

    vec3_fixed_point_alu_unit i_dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    v3alu_checker i_checker (
        .clk(clk), .rst_n(rst_n), .req_mon(req), .rsp_mon(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    always #2 clk = ~clk;

    // The receiver stalls about a quarter of the time, except during the calm stretch.
    initial rsp.ready = 1'b0;
    always @(posedge clk)
        rsp.ready <= calm_stretch ? 1'b1 : ($urandom_range(99) >= 26);

    // Watchdog: any long run without a transfer on either channel ends the test.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic word_t random_word();
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'($signed($urandom_range(131072)) - 65536);
            3: return word_t'($signed($urandom_range(1 << 24)) - (1 << 23));
            default: return word_t'($urandom);
        endcase
    endfunction

    // Hold one request until the block accepts it; insert random gaps before it.
    task automatic send_request(input cmd_t cmd, input word_t ax, input word_t ay,
        input word_t az, input word_t bx, input word_t by, input word_t bz, input word_t s);
        while (!calm_stretch && $urandom_range(99) < 26)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.a_x <= ax; req.a_y <= ay; req.a_z <= az;
        req.b_x <= bx; req.b_y <= by; req.b_z <= bz;
        req.scalar_in <= s;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    initial
    begin
        int drain;
        cmd_t cmd;
        req.valid = 1'b0;
        req.command = '0;
        req.a_x = '0; req.a_y = '0; req.a_z = '0;
        req.b_x = '0; req.b_y = '0; req.b_z = '0;
        req.scalar_in = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every command, extreme words, the zero vector on unit,
        // negation of the most negative word, and saturating sums and products.
        for (int c = 0; c < 8; c++)
            send_request(cmd_t'(c), WORD_MAX, WORD_MIN, 32'sh0001_8000,
                WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN);
        for (int c = 0; c < 8; c++)
            send_request(cmd_t'(c), 32'sh0000_8000, -32'sh0000_8000, 32'sh0003_0000,
                32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0002_0000, 32'sh0000_8000);
        send_request(CMD_UNIT, 0, 0, 0, 1, 2, 3, 4);
        send_request(CMD_MAG, 0, 0, 0, 0, 0, 0, 0);
        send_request(CMD_UNIT, 1, 0, 0, 0, 0, 0, 0);
        send_request(CMD_NEG, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0);
        send_request(CMD_MAG, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0);
        send_request(CMD_UNIT, WORD_MIN, WORD_MAX, 0, 0, 0, 0, 0);
        send_request(CMD_SCALE, -1, 32'sh0000_8000, -32'sh0000_8000, 0, 0, 0, 1);

        // Random part, with a calm stretch in the middle where nobody stalls.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm_stretch = (n >= 400 && n < 600);
            cmd = cmd_t'($urandom_range(7));
            if (cmd == CMD_UNIT && $urandom_range(15) == 0)
                send_request(cmd, 0, 0, 0, random_word(), random_word(), random_word(),
                    random_word());
            else
                send_request(cmd, random_word(), random_word(), random_word(),
                    random_word(), random_word(), random_word(), random_word());
        end
        calm_stretch = 1'b0;
        req.valid <= 1'b0;

        // Drain: wait for every expectation, then a bounded tail for stray results.
        drain = 0;
        while (pending != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (2 * PIPE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/v3alu_pkg.sv
hdl/v3alu_req_if.sv
hdl/v3alu_rsp_if.sv
hdl/vec3_fixed_point_alu_unit.sv
test/v3alu_tb_if.sv
test/v3alu_checker.sv
test/tb_top.sv
